// ===== hw/rtl/clc_pkg.sv =====
// Shared constants, command types and widths for the circular log capture block.
package clc_pkg;

  // Store depth; must be a power of two (16 .. 65536).
  localparam int unsigned BUFFER_DEPTH = 16384;
  localparam int unsigned ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int unsigned CNT_W        = ADDR_W + 1;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned LIMIT_W      = 17;

  localparam int unsigned IN_TDATA_W  = ((BYTE_W + LIMIT_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((BYTE_W + CNT_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_READ   = 2'd2
  } mode_e;

  // Classified command; CMD_NONE covers the unused mode and a zero-limit open.
  typedef enum logic [1:0] {
    CMD_APPEND,
    CMD_OPEN,
    CMD_READ,
    CMD_NONE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [BYTE_W-1:0]  data_byte;
    logic [LIMIT_W-1:0] cap;       // limit minus one
  } cmd_t;

endpackage

// ===== hw/rtl/clc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module clc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/clc_front.sv =====
// Front end: accepts input transactions, classifies them and queues the commands.
module clc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [clc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  logic [clc_pkg::MODE_W-1:0]     s_axis_tuser,
  output logic                           cmd_valid_o,
  output clc_pkg::cmd_t                  cmd_o,
  input  logic                           cmd_pop_i
);

  clc_pkg::cmd_t                      slot_q [2];
  logic                               wr_ptr_q, wr_ptr_d;
  logic                               rd_ptr_q, rd_ptr_d;
  logic [1:0]                         count_q, count_d;
  clc_pkg::cmd_t                      cmd_in;
  logic [clc_pkg::LIMIT_W-1:0]        limit;
  logic                               push, pop;

  assign limit = s_axis_tdata[clc_pkg::BYTE_W +: clc_pkg::LIMIT_W];

  always_comb begin
    cmd_in.data_byte = s_axis_tdata[clc_pkg::BYTE_W-1:0];
    cmd_in.cap       = limit - clc_pkg::LIMIT_W'(1);
    case (clc_pkg::mode_e'(s_axis_tuser))
      clc_pkg::MODE_APPEND: cmd_in.kind = clc_pkg::CMD_APPEND;
      clc_pkg::MODE_OPEN: begin
        cmd_in.kind = (limit == '0) ? clc_pkg::CMD_NONE : clc_pkg::CMD_OPEN;
      end
      clc_pkg::MODE_READ:   cmd_in.kind = clc_pkg::CMD_READ;
      default:              cmd_in.kind = clc_pkg::CMD_NONE;
    endcase
  end

  assign s_axis_tready = (count_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = cmd_pop_i && (count_q != 2'd0);

  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== hw/rtl/clc_back.sv =====
// Back end: executes queued commands against the ring store and drives the result register.
module clc_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  input  clc_pkg::cmd_t                   cmd_i,
  output logic                            cmd_pop_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [clc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast,
  output logic                            m_axis_tuser
);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  state_e                      state_q;
  logic [clc_pkg::ADDR_W-1:0]  wr_pos_q;
  logic [clc_pkg::CNT_W-1:0]   fill_q;
  logic                        wrapped_q;
  logic [clc_pkg::ADDR_W-1:0]  rd_pos_q;
  logic [clc_pkg::CNT_W-1:0]   remaining_q;
  logic                        dump_open_q;
  logic                        last_pend_q;
  logic                        out_valid_q;
  logic [clc_pkg::BYTE_W-1:0]  out_byte_q;
  logic [clc_pkg::CNT_W-1:0]   out_count_q;
  logic                        out_last_q;
  logic                        out_none_q;

  logic                        out_free;
  logic                        ram_we, ram_re;
  logic [clc_pkg::BYTE_W-1:0]  ram_rdata;
  logic [clc_pkg::CNT_W-1:0]   take;
  logic [clc_pkg::CNT_W-1:0]   skip;
  logic [clc_pkg::ADDR_W-1:0]  start;
  logic                        do_append;

  assign out_free  = !out_valid_q || m_axis_tready;
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i && out_free;

  // Dump sizing: lesser of fill count and limit minus one
  always_comb begin
    if (clc_pkg::LIMIT_W'(fill_q) < cmd_i.cap) begin
      take = fill_q;
    end else begin
      take = cmd_i.cap[clc_pkg::CNT_W-1:0];
    end
    skip  = fill_q - take;
    start = wrapped_q ? wr_pos_q : '0;
  end

  assign do_append = cmd_pop_o && (cmd_i.kind == clc_pkg::CMD_APPEND) && !dump_open_q;
  assign ram_we    = do_append;
  assign ram_re    = cmd_pop_o && (cmd_i.kind == clc_pkg::CMD_READ) && (remaining_q != '0);

  clc_ram #(
    .WIDTH(clc_pkg::BYTE_W),
    .DEPTH(clc_pkg::BUFFER_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_pos_q),
    .wdata_i(cmd_i.data_byte),
    .re_i   (ram_re),
    .raddr_i(rd_pos_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_pos_q    <= '0;
      fill_q      <= '0;
      wrapped_q   <= 1'b0;
      rd_pos_q    <= '0;
      remaining_q <= '0;
      dump_open_q <= 1'b0;
      last_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_count_q <= '0;
      out_last_q  <= 1'b0;
      out_none_q  <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o) begin
            out_byte_q  <= '0;
            out_count_q <= '0;
            out_last_q  <= 1'b0;
            out_none_q  <= 1'b0;
            out_valid_q <= 1'b1;
            case (cmd_i.kind)
              clc_pkg::CMD_APPEND: begin
                if (do_append) begin
                  wr_pos_q <= wr_pos_q + clc_pkg::ADDR_W'(1);
                  if (fill_q < clc_pkg::CNT_W'(clc_pkg::BUFFER_DEPTH)) begin
                    fill_q <= fill_q + clc_pkg::CNT_W'(1);
                  end else begin
                    wrapped_q <= 1'b1;
                  end
                end
              end
              clc_pkg::CMD_OPEN: begin
                rd_pos_q    <= start + skip[clc_pkg::ADDR_W-1:0];
                remaining_q <= take;
                dump_open_q <= (take != '0);
                out_count_q <= take;
              end
              clc_pkg::CMD_READ: begin
                if (remaining_q == '0) begin
                  out_none_q  <= 1'b1;
                  dump_open_q <= 1'b0;
                end else begin
                  // byte arrives from the store next cycle
                  out_valid_q <= 1'b0;
                  rd_pos_q    <= rd_pos_q + clc_pkg::ADDR_W'(1);
                  remaining_q <= remaining_q - clc_pkg::CNT_W'(1);
                  last_pend_q <= (remaining_q == clc_pkg::CNT_W'(1));
                  if (remaining_q == clc_pkg::CNT_W'(1)) begin
                    dump_open_q <= 1'b0;
                  end
                  state_q <= ST_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          // result register was freed when the read was issued
          out_valid_q <= 1'b1;
          out_byte_q  <= ram_rdata;
          out_last_q  <= last_pend_q;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = clc_pkg::OUT_TDATA_W'({out_count_q, out_byte_q});
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_none_q;

endmodule

// ===== hw/rtl/circular_log_capture.sv =====
// Top level of the circular log capture block: front end, command queue and back end.
//
//   channel   dir  tdata (low bit up)                      tlast      tuser
//   s_axis    in   data_byte[7:0], dump_limit[24:8]         -          mode[1:0]
//   m_axis    out  read_byte[7:0], copy_count[22:8]         last_byte  nothing_left
//
// Append, open-dump and unused-mode commands finish in the idle state; a read that
// returns a byte also waits in ST_READ on the registered read port of the store RAM.
// A two-entry command queue lets the input side keep accepting while the back end waits.
// Reset clears pointers, counts and flags; the store is not cleared (no clearing pass).
// A stalled output holds the back end; the queue then fills and drops s_axis_tready.
module circular_log_capture (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [clc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // data_byte, dump_limit
  input  logic [clc_pkg::MODE_W-1:0]      s_axis_tuser,  // mode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [clc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // read_byte, copy_count
  output logic                            m_axis_tlast,
  output logic                            m_axis_tuser   // nothing_left
);

  logic          cmd_valid;
  logic          cmd_pop;
  clc_pkg::cmd_t cmd;

  clc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  clc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule
